// ----- sv/ptc_pkg.sv -----
// Shared types and constants of the per-key traffic counter table.
package ptc_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W         = 32;
    localparam int LEN_W         = 32;
    localparam int CNT_W         = 64;

    localparam logic CMD_COUNT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic DIR_TX = 1'b0;
    localparam logic DIR_RX = 1'b1;

    localparam logic [2:0] ST_COUNTED   = 3'd0;
    localparam logic [2:0] ST_NEW       = 3'd1;
    localparam logic [2:0] ST_IGNORED   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_READ_HIT  = 3'd4;
    localparam logic [2:0] ST_READ_MISS = 3'd5;

    typedef struct packed {
        logic             cmd;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] length;
        logic             direction;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       status;
        logic [CNT_W-1:0] rx_byte_total;
        logic [CNT_W-1:0] rx_packet_total;
        logic [CNT_W-1:0] tx_byte_total;
        logic [CNT_W-1:0] tx_packet_total;
    } t_out_item;

    // One row of the counter memory.
    typedef struct packed {
        logic [CNT_W-1:0] rx_bytes;
        logic [CNT_W-1:0] rx_packets;
        logic [CNT_W-1:0] tx_bytes;
        logic [CNT_W-1:0] tx_packets;
    } t_counters;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CNT,
        S_MISS,
        S_DONE
    } t_state;

endpackage

// ----- sv/per_key_traffic_counter_table.sv -----
// Per-key traffic counter table: top level with lookup sequencer and memories.
//
// This block keeps receive and transmit byte and packet counters for up to
// TABLE_ENTRIES interfaces, each entry keyed by a nonzero 32-bit interface
// number. A count transaction adds its length and one packet to the counters
// of its direction, taking the next free entry on a miss; a read transaction
// returns an entry's four counters. Every input transaction gives exactly one
// result transaction. Keys live in one synchronous memory and counters in
// another; entries are filled in order and never freed, so a fill count marks
// which entries are in use and no clearing pass is needed after reset. The
// lookup walks the key memory through its single read port one entry per
// cycle, so the time an item takes depends on where its key sits: a hit on
// entry h is found once entries 0 to h have been compared, a miss once every
// entry in use has been compared, and a count with zero key or zero length
// skips the lookup and goes straight to its result. One item is worked on at a
// time; the result register frees the input side, so the next item can be
// accepted while the previous result still waits to be taken.
module per_key_traffic_counter_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ptc_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ptc_pkg::t_out_item o_out_data
);

    ptc_pkg::t_state    r_state, n_state;
    ptc_pkg::t_in_item  r_item, n_item;
    logic [ptc_pkg::IDX_W-1:0]  r_scan, n_scan;
    logic [ptc_pkg::FILL_W-1:0] r_fill, n_fill;
    ptc_pkg::t_out_item r_res, n_res;
    logic               r_out_valid, n_out_valid;
    ptc_pkg::t_out_item r_out_data, n_out_data;

    // Memory ports.
    logic                        key_we;
    logic [ptc_pkg::IDX_W-1:0]   key_waddr;
    logic [ptc_pkg::IDX_W-1:0]   key_raddr;
    logic [ptc_pkg::KEY_W-1:0]   key_rdata;
    logic                        cnt_we;
    logic [ptc_pkg::IDX_W-1:0]   cnt_waddr;
    logic [ptc_pkg::IDX_W-1:0]   cnt_raddr;
    ptc_pkg::t_counters          cnt_wdata;
    ptc_pkg::t_counters          cnt_rdata;
    ptc_pkg::t_counters          upd;

    logic table_full;
    logic scan_last;

    function automatic ptc_pkg::t_out_item make_result(
        input logic [2:0]         status,
        input ptc_pkg::t_counters c
    );
        ptc_pkg::t_out_item r;
        r.status          = status;
        r.rx_byte_total   = c.rx_bytes;
        r.rx_packet_total = c.rx_packets;
        r.tx_byte_total   = c.tx_bytes;
        r.tx_packet_total = c.tx_packets;
        return r;
    endfunction

    ptc_ram #(
        .WIDTH (ptc_pkg::KEY_W),
        .DEPTH (ptc_pkg::TABLE_ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (r_item.key),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    ptc_ram #(
        .WIDTH ($bits(ptc_pkg::t_counters)),
        .DEPTH (ptc_pkg::TABLE_ENTRIES)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    // In the miss state the update starts from zero, which builds the first
    // row of a new entry; in the counter state it adds to the stored row.
    ptc_update u_update (
        .i_base      (cnt_rdata),
        .i_fresh     (r_state == ptc_pkg::S_MISS),
        .i_length    (r_item.length),
        .i_direction (r_item.direction),
        .o_counters  (upd)
    );

    assign table_full = (r_fill == ptc_pkg::FILL_W'(ptc_pkg::TABLE_ENTRIES));
    assign scan_last  = ((ptc_pkg::FILL_W'(r_scan) + ptc_pkg::FILL_W'(1)) == r_fill);

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_scan      = r_scan;
        n_fill      = r_fill;
        n_res       = r_res;
        // A waiting result leaves the output register once it is taken.
        n_out_valid = r_out_valid & i_out_stall;
        n_out_data  = r_out_data;
        o_in_stall  = 1'b1;
        key_we      = 1'b0;
        key_waddr   = ptc_pkg::IDX_W'(r_fill);
        key_raddr   = r_scan;
        cnt_we      = 1'b0;
        cnt_waddr   = r_scan;
        cnt_raddr   = r_scan;
        cnt_wdata   = upd;

        unique case (r_state)
            ptc_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_item = i_in_data;
                    if (i_in_data.cmd == ptc_pkg::CMD_COUNT &&
                        (i_in_data.key == '0 || i_in_data.length == '0)) begin
                        n_res   = make_result(ptc_pkg::ST_IGNORED, '0);
                        n_state = ptc_pkg::S_DONE;
                    end else if (r_fill == '0) begin
                        n_state = ptc_pkg::S_MISS;
                    end else begin
                        n_scan    = '0;
                        key_raddr = '0;
                        n_state   = ptc_pkg::S_SCAN;
                    end
                end
            end
            ptc_pkg::S_SCAN: begin
                // The key memory output holds the key of entry r_scan.
                if (key_rdata == r_item.key) begin
                    cnt_raddr = r_scan;
                    n_state   = ptc_pkg::S_CNT;
                end else if (scan_last) begin
                    n_state = ptc_pkg::S_MISS;
                end else begin
                    n_scan    = r_scan + ptc_pkg::IDX_W'(1);
                    key_raddr = n_scan;
                end
            end
            ptc_pkg::S_CNT: begin
                if (r_item.cmd == ptc_pkg::CMD_READ) begin
                    n_res = make_result(ptc_pkg::ST_READ_HIT, cnt_rdata);
                end else begin
                    cnt_we    = 1'b1;
                    cnt_waddr = r_scan;
                    cnt_wdata = upd;
                    n_res     = make_result(ptc_pkg::ST_COUNTED, upd);
                end
                n_state = ptc_pkg::S_DONE;
            end
            ptc_pkg::S_MISS: begin
                if (r_item.cmd == ptc_pkg::CMD_READ) begin
                    n_res = make_result(ptc_pkg::ST_READ_MISS, '0);
                end else if (table_full) begin
                    n_res = make_result(ptc_pkg::ST_FULL, '0);
                end else begin
                    // Take the next free entry; entries are never freed, so it
                    // is always the lowest free one.
                    key_we    = 1'b1;
                    key_waddr = ptc_pkg::IDX_W'(r_fill);
                    cnt_we    = 1'b1;
                    cnt_waddr = ptc_pkg::IDX_W'(r_fill);
                    cnt_wdata = upd;
                    n_fill    = r_fill + ptc_pkg::FILL_W'(1);
                    n_res     = make_result(ptc_pkg::ST_NEW, upd);
                end
                n_state = ptc_pkg::S_DONE;
            end
            ptc_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = ptc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ptc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptc_pkg::S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_scan     <= n_scan;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- sv/ptc_ram.sv -----
// Simple dual-port synchronous RAM with a registered read port.
module ptc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/ptc_update.sv -----
// Counter update: adds one packet of a given length to a row of counters.
module ptc_update (
    input  ptc_pkg::t_counters              i_base,
    input  logic                            i_fresh,
    input  logic [ptc_pkg::LEN_W-1:0]       i_length,
    input  logic                            i_direction,
    output ptc_pkg::t_counters              o_counters
);

    ptc_pkg::t_counters base;
    logic [ptc_pkg::CNT_W-1:0] len_ext;

    // A freshly taken entry starts from zero counters.
    assign base    = i_fresh ? '0 : i_base;
    assign len_ext = ptc_pkg::CNT_W'(i_length);

    always_comb begin
        o_counters = base;
        if (i_direction == ptc_pkg::DIR_RX) begin
            o_counters.rx_bytes   = base.rx_bytes + len_ext;
            o_counters.rx_packets = base.rx_packets + ptc_pkg::CNT_W'(1);
        end else begin
            o_counters.tx_bytes   = base.tx_bytes + len_ext;
            o_counters.tx_packets = base.tx_packets + ptc_pkg::CNT_W'(1);
        end
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the per-key traffic counter table.
module tb_top;

    // The slowest correct run stays far below this: about 1850 transactions,
    // each scanning at most the whole table, plus sender gaps, receiver stalls
    // and one long output hold-off.
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 1830;
    localparam int KEY_POOL_SIZE = 96;
    localparam int HOLD_CYCLES   = 600;
    // Covers any late result, even one from a miss with a full table.
    localparam int DRAIN_CYCLES  = 80;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    ptc_pkg::t_in_item  i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    ptc_pkg::t_out_item o_out_data;

    per_key_traffic_counter_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // One row of the directed part. Where the expected totals are obvious they
    // are typed in and used in place of the predicted ones.
    typedef struct {
        ptc_pkg::t_in_item  item;
        bit                 typed;
        ptc_pkg::t_out_item want;
    } t_dir_row;

    // Shadow copy of the table that the predictor keeps up to date.
    bit                        slot_used [ptc_pkg::TABLE_ENTRIES];
    logic [ptc_pkg::KEY_W-1:0] slot_key  [ptc_pkg::TABLE_ENTRIES];
    ptc_pkg::t_counters        slot_cnt  [ptc_pkg::TABLE_ENTRIES];

    ptc_pkg::t_out_item        pending_totals [$];
    t_dir_row                  directed_rows  [$];
    logic [ptc_pkg::KEY_W-1:0] key_pool       [KEY_POOL_SIZE];

    int  mismatch_count  = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  cycle_count     = 0;
    int  status_seen [8];
    bit  flood_started   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Works out the result of one transaction and applies its effect to the
    // shadow table. A count hit updates the counters of the packet's direction;
    // a count miss takes the lowest free entry, if any, starting from this packet.
    function automatic ptc_pkg::t_out_item predict_totals(input ptc_pkg::t_in_item it);
        ptc_pkg::t_out_item res;
        ptc_pkg::t_counters c;
        int                 hit;
        int                 free_slot;
        int                 shown;
        int                 i;
        res       = '0;
        hit       = -1;
        free_slot = -1;
        shown     = -1;
        for (i = ptc_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (slot_used[i] && slot_key[i] == it.key) begin
                hit = i;
            end
            if (!slot_used[i]) begin
                free_slot = i;
            end
        end
        if (it.cmd == ptc_pkg::CMD_READ) begin
            // Length and direction play no part in a read.
            res.status = (hit >= 0) ? ptc_pkg::ST_READ_HIT : ptc_pkg::ST_READ_MISS;
            shown      = hit;
        end else if (it.key == '0 || it.length == '0) begin
            res.status = ptc_pkg::ST_IGNORED;
        end else if (hit >= 0) begin
            c = slot_cnt[hit];
            if (it.direction == ptc_pkg::DIR_RX) begin
                c.rx_bytes   = c.rx_bytes + ptc_pkg::CNT_W'(it.length);
                c.rx_packets = c.rx_packets + ptc_pkg::CNT_W'(1);
            end else begin
                c.tx_bytes   = c.tx_bytes + ptc_pkg::CNT_W'(it.length);
                c.tx_packets = c.tx_packets + ptc_pkg::CNT_W'(1);
            end
            slot_cnt[hit] = c;
            res.status    = ptc_pkg::ST_COUNTED;
            shown         = hit;
        end else if (free_slot < 0) begin
            res.status = ptc_pkg::ST_FULL;
        end else begin
            c = '0;
            if (it.direction == ptc_pkg::DIR_RX) begin
                c.rx_bytes   = ptc_pkg::CNT_W'(it.length);
                c.rx_packets = ptc_pkg::CNT_W'(1);
            end else begin
                c.tx_bytes   = ptc_pkg::CNT_W'(it.length);
                c.tx_packets = ptc_pkg::CNT_W'(1);
            end
            slot_used[free_slot] = 1'b1;
            slot_key[free_slot]  = it.key;
            slot_cnt[free_slot]  = c;
            res.status           = ptc_pkg::ST_NEW;
            shown                = free_slot;
        end
        if (shown >= 0) begin
            res.rx_byte_total   = slot_cnt[shown].rx_bytes;
            res.rx_packet_total = slot_cnt[shown].rx_packets;
            res.tx_byte_total   = slot_cnt[shown].tx_bytes;
            res.tx_packet_total = slot_cnt[shown].tx_packets;
        end
        return res;
    endfunction

    function automatic ptc_pkg::t_out_item totals(
        input logic [2:0]                st,
        input logic [ptc_pkg::CNT_W-1:0] rxb,
        input logic [ptc_pkg::CNT_W-1:0] rxp,
        input logic [ptc_pkg::CNT_W-1:0] txb,
        input logic [ptc_pkg::CNT_W-1:0] txp
    );
        ptc_pkg::t_out_item res;
        res.status          = st;
        res.rx_byte_total   = rxb;
        res.rx_packet_total = rxp;
        res.tx_byte_total   = txb;
        res.tx_packet_total = txp;
        return res;
    endfunction

    function automatic void add_row(input logic cmd, input logic [ptc_pkg::KEY_W-1:0] key,
                                    input logic [ptc_pkg::LEN_W-1:0] len, input logic dir,
                                    input bit typed, input ptc_pkg::t_out_item want);
        t_dir_row r;
        r.item.cmd       = cmd;
        r.item.key       = key;
        r.item.length    = len;
        r.item.direction = dir;
        r.typed          = typed;
        r.want           = want;
        directed_rows.push_back(r);
    endfunction

    // Random transactions are mostly counts, drawn from a pool of keys larger
    // than the table so that hits, new entries and a full table all occur.
    // Fresh random keys and random lengths exercise every bit of both fields.
    function automatic ptc_pkg::t_in_item make_traffic_item();
        ptc_pkg::t_in_item it;
        int                pick;
        it.cmd       = ($urandom_range(3) == 0) ? ptc_pkg::CMD_READ : ptc_pkg::CMD_COUNT;
        it.direction = 1'($urandom_range(1));
        pick         = $urandom_range(99);
        if (pick < 4) begin
            it.key = '0;
        end else if (pick < 16) begin
            it.key = $urandom;
        end else begin
            it.key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        end
        pick = $urandom_range(99);
        if (pick < 4) begin
            it.length = '0;
        end else if (pick < 10) begin
            it.length = '1;
        end else if (pick < 35) begin
            it.length = $urandom;
        end else begin
            it.length = $urandom_range(1518, 1);
        end
        return it;
    endfunction

    // Offers one transaction and holds it until the block takes it. The
    // expectation is queued at the edge where the transaction is accepted.
    task automatic offer(input ptc_pkg::t_in_item it, input bit typed,
                         input ptc_pkg::t_out_item typed_want);
        ptc_pkg::t_out_item predicted;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predicted = predict_totals(it);
        pending_totals.push_back(typed ? typed_want : predicted);
        items_sent++;
    endtask

    // Lowers valid and waits until every result is back.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_totals.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [ptc_pkg::CNT_W-1:0] want,
                               input logic [ptc_pkg::CNT_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Result side: every accepted result is checked against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        ptc_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_totals.size() == 0) begin
                $error("result with no transaction pending: status %0d", o_out_data.status);
                mismatch_count++;
            end else begin
                want = pending_totals.pop_front();
                check_field("status", ptc_pkg::CNT_W'(want.status),
                            ptc_pkg::CNT_W'(o_out_data.status));
                check_field("rx_byte_total", want.rx_byte_total, o_out_data.rx_byte_total);
                check_field("rx_packet_total", want.rx_packet_total,
                            o_out_data.rx_packet_total);
                check_field("tx_byte_total", want.tx_byte_total, o_out_data.tx_byte_total);
                check_field("tx_packet_total", want.tx_packet_total,
                            o_out_data.tx_packet_total);
                status_seen[want.status]++;
                results_checked++;
            end
        end
    end

    // Receiver: stalls on segments of random length, each with its own
    // pattern (never, light, heavy, periodic). Once the random traffic starts
    // it holds off for a long stretch so that the block backs up and stalls
    // its input while the sender keeps offering.
    initial begin
        bit hold_done;
        int seg_len;
        int mode;
        int period;
        int k;
        hold_done = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (flood_started && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                seg_len = $urandom_range(150, 10);
                mode    = $urandom_range(3);
                period  = $urandom_range(7, 2);
                for (k = 0; k < seg_len; k++) begin
                    case (mode)
                        0: begin
                            i_out_stall <= 1'b0;
                        end
                        1: begin
                            i_out_stall <= ($urandom_range(3) == 0);
                        end
                        2: begin
                            i_out_stall <= ($urandom_range(3) != 0);
                        end
                        default: begin
                            i_out_stall <= ((k % period) < (period / 2));
                        end
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Sender and overall sequencing.
    initial begin
        int       burst;
        int       gap;
        int       b;
        int       i;
        int       used;
        t_dir_row r;

        for (i = 0; i < ptc_pkg::TABLE_ENTRIES; i++) begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_cnt[i]  = '0;
        end
        for (i = 0; i < 8; i++) begin
            status_seen[i] = 0;
        end
        for (i = 0; i < KEY_POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
            if (key_pool[i] == '0) begin
                key_pool[i] = 1;
            end
        end

        // Directed part. Entries are taken in order: all-ones key in entry 0,
        // key one in entry 1, the top-bit key in entry 2, 0x7fffffff in entry 3.
        // Read misses, including key zero, which is never stored.
        add_row(ptc_pkg::CMD_READ, 32'h0, 32'h0, ptc_pkg::DIR_TX, 1'b1,
                totals(ptc_pkg::ST_READ_MISS, 0, 0, 0, 0));
        add_row(ptc_pkg::CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ptc_pkg::DIR_RX, 1'b1,
                totals(ptc_pkg::ST_READ_MISS, 0, 0, 0, 0));
        // Ignored packets: zero key, zero length, or both.
        add_row(ptc_pkg::CMD_COUNT, 32'h0, 32'd100, ptc_pkg::DIR_RX, 1'b1,
                totals(ptc_pkg::ST_IGNORED, 0, 0, 0, 0));
        add_row(ptc_pkg::CMD_COUNT, 32'h5, 32'h0, ptc_pkg::DIR_TX, 1'b1,
                totals(ptc_pkg::ST_IGNORED, 0, 0, 0, 0));
        add_row(ptc_pkg::CMD_COUNT, 32'h0, 32'h0, ptc_pkg::DIR_RX, 1'b1,
                totals(ptc_pkg::ST_IGNORED, 0, 0, 0, 0));
        // Largest key and length, back to back on the same entry in both
        // directions, so each must build on the update written just before it.
        add_row(ptc_pkg::CMD_COUNT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ptc_pkg::DIR_RX, 1'b1,
                totals(ptc_pkg::ST_NEW, 64'hFFFF_FFFF, 1, 0, 0));
        add_row(ptc_pkg::CMD_COUNT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ptc_pkg::DIR_TX, 1'b1,
                totals(ptc_pkg::ST_COUNTED, 64'hFFFF_FFFF, 1, 64'hFFFF_FFFF, 1));
        add_row(ptc_pkg::CMD_COUNT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ptc_pkg::DIR_RX, 1'b0, '0);
        add_row(ptc_pkg::CMD_COUNT, 32'h1, 32'h1, ptc_pkg::DIR_TX, 1'b1,
                totals(ptc_pkg::ST_NEW, 0, 0, 1, 1));
        add_row(ptc_pkg::CMD_COUNT, 32'h8000_0000, 32'h8000_0000, ptc_pkg::DIR_RX, 1'b1,
                totals(ptc_pkg::ST_NEW, 64'h8000_0000, 1, 0, 0));
        // Read hits, then a miss; a read's length and direction must be ignored.
        add_row(ptc_pkg::CMD_READ, 32'h1, 32'hFFFF_FFFF, ptc_pkg::DIR_RX, 1'b0, '0);
        add_row(ptc_pkg::CMD_READ, 32'hFFFF_FFFF, 32'h0, ptc_pkg::DIR_TX, 1'b0, '0);
        add_row(ptc_pkg::CMD_READ, 32'h8000_0000, 32'h1234_5678, ptc_pkg::DIR_RX, 1'b0, '0);
        add_row(ptc_pkg::CMD_READ, 32'h2, 32'h0, ptc_pkg::DIR_TX, 1'b1,
                totals(ptc_pkg::ST_READ_MISS, 0, 0, 0, 0));
        // Repeated hits on one entry, then a read right behind them.
        add_row(ptc_pkg::CMD_COUNT, 32'h1, 32'd1500, ptc_pkg::DIR_TX, 1'b0, '0);
        add_row(ptc_pkg::CMD_COUNT, 32'h1, 32'd1500, ptc_pkg::DIR_TX, 1'b0, '0);
        add_row(ptc_pkg::CMD_COUNT, 32'h1, 32'd1500, ptc_pkg::DIR_TX, 1'b0, '0);
        add_row(ptc_pkg::CMD_COUNT, 32'h1, 32'd64, ptc_pkg::DIR_RX, 1'b0, '0);
        add_row(ptc_pkg::CMD_READ, 32'h1, 32'h0, ptc_pkg::DIR_TX, 1'b0, '0);
        add_row(ptc_pkg::CMD_COUNT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ptc_pkg::DIR_TX, 1'b1,
                totals(ptc_pkg::ST_NEW, 0, 0, 64'h7FFF_FFFF, 1));
        add_row(ptc_pkg::CMD_READ, 32'h7FFF_FFFF, 32'h0, ptc_pkg::DIR_RX, 1'b0, '0);
        add_row(ptc_pkg::CMD_READ, 32'h0, 32'hFFFF_FFFF, ptc_pkg::DIR_RX, 1'b1,
                totals(ptc_pkg::ST_READ_MISS, 0, 0, 0, 0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The directed rows go in back to back, with no gaps on the input side.
        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            offer(r.item, r.typed, r.want);
        end
        wait_for_drain();

        // Random traffic in bursts with random gaps. Halfway through, the
        // sender stops until every result is back, then carries on.
        flood_started = 1'b1;
        i = 0;
        while (i < RANDOM_ITEMS) begin
            burst = $urandom_range(24, 1);
            for (b = 0; b < burst && i < RANDOM_ITEMS; b++) begin
                offer(make_traffic_item(), 1'b0, '0);
                i++;
                if (i == RANDOM_ITEMS / 2) begin
                    wait_for_drain();
                end
            end
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_totals.size() != 0) begin
            $error("%0d results never arrived", pending_totals.size());
            mismatch_count++;
        end

        used = 0;
        for (i = 0; i < ptc_pkg::TABLE_ENTRIES; i++) begin
            used += slot_used[i];
        end
        $display("Summary: %0d transactions sent, %0d results checked, %0d of %0d entries used.",
                 items_sent, results_checked, used, ptc_pkg::TABLE_ENTRIES);
        $display("Results seen: counted %0d, new %0d, ignored %0d, full %0d,",
                 status_seen[ptc_pkg::ST_COUNTED], status_seen[ptc_pkg::ST_NEW],
                 status_seen[ptc_pkg::ST_IGNORED], status_seen[ptc_pkg::ST_FULL]);
        $display("  read hit %0d, read miss %0d.",
                 status_seen[ptc_pkg::ST_READ_HIT], status_seen[ptc_pkg::ST_READ_MISS]);
        if (mismatch_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
